// File: sv/rect_line_clipper_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle line clipper.
// Each macro expands to a labeled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef RECT_LINE_CLIPPER_MACROS_SVH
`define RECT_LINE_CLIPPER_MACROS_SVH
`ifndef SYNTHESIS
`define RLC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RLC_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLC_ASSERT(label, clk, rstn, prop, msg)
`define RLC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: sv/rlc_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle line clipper package
// Register indexes and outcode bit positions.
// ----------------------------------------------------------------------------
package rlc_pkg;
    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_X_MAX = 2'd1;
    localparam logic [1:0] REG_Y_MIN = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;
    localparam int OC_BELOW = 0;
    localparam int OC_ABOVE = 1;
    localparam int OC_RIGHT = 2;
    localparam int OC_LEFT  = 3;
endpackage

// File: sv/rect_line_clipper.sv
// ----------------------------------------------------------------------------
// Rectangle line clipper
// Clips one segment to a configured window with outcodes and one shared
// restoring divider.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports
// s_       in         s_valid s_ready s_start_x s_start_y s_end_x s_end_y
// m_       out        m_valid m_ready m_status m_out_start_x .. m_out_end_y
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data
//
// Each clipped edge passes through an edge check, a multiply, the divide
// steps and a write-back. A skipped edge takes only the edge check, and each
// round begins with a decision, for up to MAX_ROUNDS rounds. Reset clears all
// control state and loads the default window. The input is not ready while a
// segment is at work or its result waits on the output.
module rect_line_clipper #(
    parameter int COORD_WIDTH = 16,
    parameter int MAX_ROUNDS  = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_end_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic signed [COORD_WIDTH-1:0] m_out_start_x,
    output logic signed [COORD_WIDTH-1:0] m_out_start_y,
    output logic signed [COORD_WIDTH-1:0] m_out_end_x,
    output logic signed [COORD_WIDTH-1:0] m_out_end_y,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic signed [15:0]            cfg_data
);
    `include "rect_line_clipper_macros.svh"

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int CW = $clog2(PW + 1);
    localparam int RW = $clog2(MAX_ROUNDS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_STEP  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic signed [W+1:0] CMAX = $signed({3'b000, {(W-1){1'b1}}});
    localparam logic signed [W+1:0] CMIN = -$signed({3'b001, {(W-1){1'b0}}});

    logic [2:0] state_reg;
    logic signed [W-1:0] wxl_reg, wxh_reg, wyl_reg, wyh_reg;
    logic signed [W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [3:0] code_reg;
    logic [1:0] edge_reg;
    logic [RW-1:0] round_reg;
    logic [PW-1:0] prod_reg;
    logic [DW-1:0] dm_reg;
    logic [DW:0] rem_reg;
    logic [PW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic neg_reg;
    logic status_reg;

    function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                           input logic signed [W-1:0] y,
                                           input logic signed [W-1:0] xl,
                                           input logic signed [W-1:0] xh,
                                           input logic signed [W-1:0] yl,
                                           input logic signed [W-1:0] yh);
        logic [3:0] c;
        c = '0;
        c[rlc_pkg::OC_BELOW] = y < yl;
        c[rlc_pkg::OC_ABOVE] = y > yh;
        c[rlc_pkg::OC_RIGHT] = x > xh;
        c[rlc_pkg::OC_LEFT]  = x < xl;
        return c;
    endfunction

    logic [3:0] c1, c2;
    assign c1 = outcode(x1_reg, y1_reg, wxl_reg, wxh_reg, wyl_reg, wyh_reg);
    assign c2 = outcode(x2_reg, y2_reg, wxl_reg, wxh_reg, wyl_reg, wyh_reg);

    // Edge operands: horizontal edges move x, vertical edges move y.
    logic horiz;
    logic signed [W-1:0] edge_val;
    logic signed [DW-1:0] op_p, op_q, op_d;
    always_comb begin
        horiz = (edge_reg == 2'd0) || (edge_reg == 2'd1);
        case (edge_reg)
            2'd0:    edge_val = wyl_reg;
            2'd1:    edge_val = wyh_reg;
            2'd2:    edge_val = wxh_reg;
            default: edge_val = wxl_reg;
        endcase
        if (horiz) begin
            op_p = DW'(x2_reg) - DW'(x1_reg);
            op_q = DW'(edge_val) - DW'(y1_reg);
            op_d = DW'(y2_reg) - DW'(y1_reg);
        end else begin
            op_p = DW'(y2_reg) - DW'(y1_reg);
            op_q = DW'(edge_val) - DW'(x1_reg);
            op_d = DW'(x2_reg) - DW'(x1_reg);
        end
    end

    logic [DW-1:0] mp, mq, md;
    assign mp = op_p[DW-1] ? DW'(-op_p) : DW'(op_p);
    assign mq = op_q[DW-1] ? DW'(-op_q) : DW'(op_q);
    assign md = op_d[DW-1] ? DW'(-op_d) : DW'(op_d);

    logic [DW:0] rem_sh, rem_sub;
    logic take;
    assign rem_sh  = {rem_reg[DW-1:0], prod_reg[PW-1]};
    assign rem_sub = rem_sh - {1'b0, dm_reg};
    assign take    = rem_sh >= {1'b0, dm_reg};

    // The quotient is clamped to the span of the coordinate range before the
    // add, and the sum is saturated to the coordinate range.
    logic signed [W+1:0] base, qs, res, sat;
    always_comb begin
        base = horiz ? (W+2)'(x1_reg) : (W+2)'(y1_reg);
        if (quo_reg > PW'(CMAX) - PW'(CMIN)) qs = CMAX - CMIN;
        else qs = (W+2)'(quo_reg);
        res = neg_reg ? base - qs : base + qs;
        if (res > CMAX) sat = CMAX;
        else if (res < CMIN) sat = CMIN;
        else sat = res;
    end

    logic edge_ok;
    assign edge_ok = code_reg[edge_reg] && (op_d != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            wxl_reg    <= '0;
            wxh_reg    <= W'(16'sd32767);
            wyl_reg    <= '0;
            wyh_reg    <= W'(16'sd32767);
            round_reg  <= '0;
            edge_reg   <= '0;
            cnt_reg    <= '0;
            status_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    rlc_pkg::REG_X_MIN: wxl_reg <= W'(cfg_data);
                    rlc_pkg::REG_X_MAX: wxh_reg <= W'(cfg_data);
                    rlc_pkg::REG_Y_MIN: wyl_reg <= W'(cfg_data);
                    rlc_pkg::REG_Y_MAX: wyh_reg <= W'(cfg_data);
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x1_reg    <= s_start_x;
                        y1_reg    <= s_start_y;
                        x2_reg    <= s_end_x;
                        y2_reg    <= s_end_y;
                        round_reg <= '0;
                        if (s_start_x == s_end_x && s_start_y == s_end_y) begin
                            status_reg <= outcode(s_start_x, s_start_y, wxl_reg, wxh_reg,
                                                  wyl_reg, wyh_reg) != 4'd0;
                            state_reg  <= ST_OUT;
                        end else begin
                            state_reg <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND: begin
                    if (round_reg == RW'(MAX_ROUNDS)) begin
                        status_reg <= 1'b1;
                        state_reg  <= ST_OUT;
                    end else if (c1 == 4'd0 && c2 == 4'd0) begin
                        status_reg <= 1'b0;
                        state_reg  <= ST_OUT;
                    end else if ((c1 & c2) != 4'd0) begin
                        status_reg <= 1'b1;
                        state_reg  <= ST_OUT;
                    end else begin
                        if (c1 == 4'd0) begin
                            x1_reg   <= x2_reg;
                            y1_reg   <= y2_reg;
                            x2_reg   <= x1_reg;
                            y2_reg   <= y1_reg;
                            code_reg <= c2;
                        end else begin
                            code_reg <= c1;
                        end
                        round_reg <= round_reg + 1'b1;
                        edge_reg  <= 2'd0;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (edge_ok) begin
                        state_reg <= ST_MUL;
                    end else if (edge_reg == 2'd3) begin
                        state_reg <= ST_ROUND;
                    end else begin
                        edge_reg <= edge_reg + 1'b1;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PW'(mp) * PW'(mq);
                    dm_reg    <= md;
                    neg_reg   <= (op_p[DW-1] ^ op_q[DW-1]) ^ op_d[DW-1];
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= CW'(PW);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        if (horiz) begin
                            x1_reg <= W'(sat);
                            y1_reg <= edge_val;
                        end else begin
                            y1_reg <= W'(sat);
                            x1_reg <= edge_val;
                        end
                        state_reg <= (edge_reg == 2'd3) ? ST_ROUND : ST_STEP;
                        edge_reg  <= edge_reg + 1'b1;
                    end else begin
                        rem_reg  <= take ? rem_sub : rem_sh;
                        quo_reg  <= {quo_reg[PW-2:0], take};
                        prod_reg <= {prod_reg[PW-2:0], 1'b0};
                        cnt_reg  <= cnt_reg - 1'b1;
                    end
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = state_reg == ST_IDLE;
    assign cfg_ready     = 1'b1;
    assign m_valid       = state_reg == ST_OUT;
    assign m_status      = status_reg;
    assign m_out_start_x = status_reg ? '0 : x1_reg;
    assign m_out_start_y = status_reg ? '0 : y1_reg;
    assign m_out_end_x   = status_reg ? '0 : x2_reg;
    assign m_out_end_y   = status_reg ? '0 : y2_reg;

    `RLC_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status), "result changed while stalled")
    `RLC_ASSERT(a_excl, aclk, aresetn, !(s_ready && m_valid), "input ready while result pending")
    `RLC_ASSERT(a_round_lim, aclk, aresetn, round_reg <= RW'(MAX_ROUNDS), "round count overrun")
    `RLC_ASSERT(a_cnt, aclk, aresetn, state_reg == ST_DIV |-> cnt_reg <= CW'(PW), "divider count overrun")
endmodule

// File: test/tb_rect_line_clipper.sv
// ----------------------------------------------------------------------------
// Testbench for the rectangle line clipper
// Drives segments through the input channel with random gaps, predicts each
// clipped segment with a behavioral outcode clipper, and checks every result
// field by field. The window is changed between phases while the block idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rect_line_clipper;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } segment_t;

    typedef struct packed {
        logic               status;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } clipped_t;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 400;
    localparam int LONG_HOLD       = 600;
    localparam int OC_B = 1 << rlc_pkg::OC_BELOW;
    localparam int OC_A = 1 << rlc_pkg::OC_ABOVE;
    localparam int OC_R = 1 << rlc_pkg::OC_RIGHT;
    localparam int OC_L = 1 << rlc_pkg::OC_LEFT;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_start_x, s_start_y, s_end_x, s_end_y;
    logic               m_valid;
    logic               m_ready;
    logic               m_status;
    logic signed [15:0] m_out_start_x, m_out_start_y, m_out_end_x, m_out_end_y;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic signed [15:0] cfg_data;

    longint win_x_lo, win_x_hi, win_y_lo, win_y_hi;
    segment_t pending_segments[$];
    clipped_t expected_clips[$];
    int  errors;
    int  idle_cycles;
    int  hold_off;
    int  hold_req;
    int  hold_ack;
    bit  timed_out;
    bit  s_taken;

    rect_line_clipper uut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned outcode(longint x, longint y);
        int unsigned c;
        c = 0;
        if (y < win_y_lo) c |= OC_B;
        if (y > win_y_hi) c |= OC_A;
        if (x > win_x_hi) c |= OC_R;
        if (x < win_x_lo) c |= OC_L;
        return c;
    endfunction

    // base + trunc(p*q/d), saturated to 16 bits; the 128-bit product is exact.
    function automatic longint edge_point(longint base, longint p, longint q, longint d);
        logic signed [127:0] prod;
        logic signed [127:0] quo;
        logic signed [127:0] r;
        prod = 128'(signed'(p)) * 128'(signed'(q));
        quo  = prod / 128'(signed'(d));
        if (quo > (128'sd1 <<< 62)) quo = 128'sd1 <<< 62;
        if (quo < -(128'sd1 <<< 62)) quo = -(128'sd1 <<< 62);
        r = 128'(signed'(base)) + quo;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return longint'(r);
    endfunction

    function automatic clipped_t clip_segment(segment_t seg);
        longint x1, y1, x2, y2, t;
        int unsigned c1, c2;
        bit accept;
        clipped_t res;
        x1 = seg.sx; y1 = seg.sy; x2 = seg.ex; y2 = seg.ey;
        accept = 1'b0;
        if (x1 == x2 && y1 == y2) begin
            accept = (outcode(x1, y1) == 0);
        end else begin
            for (int r = 0; r < 4; r++) begin
                c1 = outcode(x1, y1);
                c2 = outcode(x2, y2);
                if (c1 == 0 && c2 == 0) begin
                    accept = 1'b1;
                    break;
                end
                if ((c1 & c2) != 0) break;
                if (c1 == 0) begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                    c1 = c2;
                end
                if ((c1 & OC_B) && y1 != y2) begin
                    x1 = edge_point(x1, x2 - x1, win_y_lo - y1, y2 - y1);
                    y1 = win_y_lo;
                end
                if ((c1 & OC_A) && y1 != y2) begin
                    x1 = edge_point(x1, x2 - x1, win_y_hi - y1, y2 - y1);
                    y1 = win_y_hi;
                end
                if ((c1 & OC_R) && x1 != x2) begin
                    y1 = edge_point(y1, y2 - y1, win_x_hi - x1, x2 - x1);
                    x1 = win_x_hi;
                end
                if ((c1 & OC_L) && x1 != x2) begin
                    y1 = edge_point(y1, y2 - y1, win_x_lo - x1, x2 - x1);
                    x1 = win_x_lo;
                end
            end
        end
        if (accept) begin
            res.status = 1'b0;
            res.sx = x1[15:0]; res.sy = y1[15:0];
            res.ex = x2[15:0]; res.ey = y2[15:0];
        end else begin
            res = '0;
            res.status = 1'b1;
        end
        return res;
    endfunction

    function automatic int gap_length();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return 0;
        if (sel < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Driver: one segment offered at a time from the pending queue.
    int send_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (s_valid && !s_taken) begin
            // Hold the offered segment.
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_segments.size() > 0) begin
            segment_t seg;
            seg = pending_segments.pop_front();
            s_valid   <= 1'b1;
            s_start_x <= seg.sx;
            s_start_y <= seg.sy;
            s_end_x   <= seg.ex;
            s_end_y   <= seg.ey;
            send_gap  <= gap_length();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Accepted segments are predicted at the edge that takes them.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_clips.push_back(clip_segment({s_start_x, s_start_y, s_end_x, s_end_y}));
        end
    end

    // Receiver readiness, with an occasional long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_off <= 0;
        end else if (hold_req != hold_ack) begin
            m_ready <= 1'b0;
            hold_ack <= hold_req;
            hold_off <= LONG_HOLD;
        end else if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if ($urandom_range(99) < 2) begin
            m_ready <= 1'b0;
            hold_off <= $urandom_range(300, 150);
        end else begin
            m_ready <= (gap_length() == 0) || ($urandom_range(1) == 1);
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            clipped_t want;
            if (expected_clips.size() == 0) begin
                $display("%0t: result with no segment pending: status %0d", $time, m_status);
                errors++;
            end else begin
                want = expected_clips.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, m_status);
                    errors++;
                end
                if (m_out_start_x !== want.sx) begin
                    $display("%0t: out_start_x expected %0d got %0d",
                             $time, want.sx, m_out_start_x);
                    errors++;
                end
                if (m_out_start_y !== want.sy) begin
                    $display("%0t: out_start_y expected %0d got %0d",
                             $time, want.sy, m_out_start_y);
                    errors++;
                end
                if (m_out_end_x !== want.ex) begin
                    $display("%0t: out_end_x expected %0d got %0d", $time, want.ex, m_out_end_x);
                    errors++;
                end
                if (m_out_end_y !== want.ey) begin
                    $display("%0t: out_end_y expected %0d got %0d", $time, want.ey, m_out_end_y);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
                timed_out = 1'b1;
                $display("tb_rect_line_clipper NOT OK");
                $finish;
            end
        end
    end

    task automatic write_window(logic [1:0] idx, logic signed [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            rlc_pkg::REG_X_MIN: win_x_lo = value;
            rlc_pkg::REG_X_MAX: win_x_hi = value;
            rlc_pkg::REG_Y_MIN: win_y_lo = value;
            default:            win_y_hi = value;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(int xl, int xh, int yl, int yh);
        write_window(rlc_pkg::REG_X_MIN, 16'(xl));
        write_window(rlc_pkg::REG_X_MAX, 16'(xh));
        write_window(rlc_pkg::REG_Y_MIN, 16'(yl));
        write_window(rlc_pkg::REG_Y_MAX, 16'(yh));
    endtask

    task automatic wait_drained();
        while (pending_segments.size() > 0 || s_valid || expected_clips.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] near_edge(longint e);
        longint v;
        v = e + $signed($urandom_range(64)) - 32;
        if ($urandom_range(3) == 0) v = $signed(16'($urandom));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic add(int a, int b, int c, int d);
        segment_t seg;
        seg.sx = 16'(a); seg.sy = 16'(b); seg.ex = 16'(c); seg.ey = 16'(d);
        pending_segments.push_back(seg);
    endtask

    task automatic add_random(int n);
        segment_t seg;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                seg = segment_t'({$urandom, $urandom});
            end else begin
                seg.sx = near_edge($urandom_range(1) ? win_x_lo : win_x_hi);
                seg.sy = near_edge($urandom_range(1) ? win_y_lo : win_y_hi);
                seg.ex = near_edge($urandom_range(1) ? win_x_lo : win_x_hi);
                seg.ey = near_edge($urandom_range(1) ? win_y_lo : win_y_hi);
                if ($urandom_range(19) == 0) begin
                    seg.ex = seg.sx;
                    seg.ey = seg.sy;
                end
            end
            pending_segments.push_back(seg);
        end
    endtask

    initial begin
        hold_req = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rlc_pkg::REG_X_MIN;
        cfg_data = '0;
        win_x_lo = 0; win_x_hi = 32767; win_y_lo = 0; win_y_hi = 32767;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default window, then directed cases in a small window.
        add(-32768, -32768, 32767, 32767);
        add(100, 100, 100, 100);
        add(-5, 3, -5, 3);
        wait_drained();
        set_window(-1600, 1600, -800, 800);
        add(0, 0, 100, 50);
        add(-2000, 0, 2000, 0);
        add(0, -2000, 0, 2000);
        add(-3000, -3000, 3000, 3000);
        add(2000, 2000, 3000, 1000);
        add(-2000, -1000, -1700, 900);
        add(0, 0, 0, 0);
        add(5000, 0, 5000, 0);
        add(-32768, 32767, 32767, -32768);
        add(32767, 32767, -32768, -32768);
        add(-32768, 0, 32767, 1);
        add(0, 0, 3000, 0);
        add(-1700, 900, 1700, -900);
        add(1500, 900, 1700, 700);
        // Long hold-off while the sender keeps offering segments.
        hold_req = hold_req + 1;
        add_random(10);
        wait_drained();
        // Inverted window.
        set_window(1000, -1000, 500, -500);
        add(0, 0, 10, 10);
        add(-2000, 0, 2000, 0);
        add_random(150);
        wait_drained();
        // Extreme window edges.
        set_window(-32768, 32767, -32768, 32767);
        add_random(100);
        wait_drained();
        set_window(32767, 32767, -32768, -32768);
        add_random(60);
        wait_drained();
        set_window(-3, 5, -7, 2);
        add_random(300);
        wait_drained();
        set_window(-20000, 16000, -9000, 31000);
        add_random(500);
        wait_drained();

        if (errors == 0) begin
            $display("tb_rect_line_clipper OK");
        end else begin
            $display("tb_rect_line_clipper NOT OK");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/rlc_pkg.sv
sv/rect_line_clipper.sv
test/tb_rect_line_clipper.sv
